// ----- design/nlrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nlrs_pkg;

  localparam int OFS_W   = 40;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int MAX_SEG = 64;
  localparam int DIV_CNT_W = $clog2(OFS_W + 1);

  localparam logic [BYTE_W-1:0] NEWLINE = BYTE_W'(10);

  // register indexes of the configuration port
  localparam logic REG_TOTAL_LEN = 1'b0;
  localparam logic REG_SEG_COUNT = 1'b1;

  typedef struct packed {
    logic take;        // latch a new byte
    logic div_start;   // first byte: start chunk division
    logic load_chunk;  // division finished, load chunk and first cut
    logic cut_nl;      // place boundary at the current position
    logic cut_end;     // place boundary at end of stream
    logic final_out;   // report the final range
  } cmd_t;

  typedef struct packed {
    logic first;       // no byte taken yet
    logic div_done;
    logic cut_nl_ok;
    logic end_reached;
    logic more;        // boundaries still open
    logic finished;
  } status_t;

endpackage
`default_nettype wire

// ----- design/newline_aligned_range_splitter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A byte with no result passes through the IDLE and CHECK states; the first byte also waits in DIV
// for the bit-serial chunk division (one quotient bit per cycle over 40 bits).
// A new byte is taken only back in IDLE; each result adds an EMIT state, stretched by out_stall.
// Results wait in an output register; no new byte is taken until they are all gone.
// Reset (rst, synchronous): stream length = 1, seg_count = 1, position and counts cleared.
module newline_aligned_range_splitter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [nlrs_pkg::OFS_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [nlrs_pkg::BYTE_W-1:0]   data_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [nlrs_pkg::IDX_W-1:0]    seg_index,
  output logic      [nlrs_pkg::OFS_W-1:0]    start_offset,
  output logic      [nlrs_pkg::OFS_W-1:0]    end_offset,
  output logic      [nlrs_pkg::OFS_W-1:0]    first_line,
  output logic                               last_seg
);

  nlrs_pkg::cmd_t    cmd;
  nlrs_pkg::status_t status;

  nlrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  nlrs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .seg_index    (seg_index),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .first_line   (first_line),
    .last_seg     (last_seg)
  );

endmodule
`default_nettype wire

// ----- design/nlrs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module nlrs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [nlrs_pkg::OFS_W-1:0]    dividend,
  input  wire logic [nlrs_pkg::CNT_W-1:0]    divisor,
  output logic      [nlrs_pkg::OFS_W-1:0]    quotient,
  output logic                               done
);

  logic [nlrs_pkg::OFS_W-1:0]     quo;
  logic [nlrs_pkg::CNT_W-1:0]     rem;
  logic [nlrs_pkg::CNT_W-1:0]     dvs;
  logic [nlrs_pkg::DIV_CNT_W-1:0] cnt;
  logic [nlrs_pkg::CNT_W:0]       trial;
  logic                           fits;

  assign trial = {rem, quo[nlrs_pkg::OFS_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= nlrs_pkg::DIV_CNT_W'(nlrs_pkg::OFS_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      // remainder stays below divisor, so it fits in CNT_W bits
      rem <= fits ? nlrs_pkg::CNT_W'(trial - {1'b0, dvs}) : trial[nlrs_pkg::CNT_W-1:0];
      quo <= {quo[nlrs_pkg::OFS_W-2:0], fits};
    end
  end

  assign quotient = quo;
  assign done     = cnt == '0;

endmodule
`default_nettype wire

// ----- design/nlrs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nlrs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [nlrs_pkg::OFS_W-1:0]    cfg_data,
  input  wire logic [nlrs_pkg::BYTE_W-1:0]   data_byte,
  input  wire nlrs_pkg::cmd_t                cmd,
  output nlrs_pkg::status_t                  status,
  output logic      [nlrs_pkg::IDX_W-1:0]    seg_index,
  output logic      [nlrs_pkg::OFS_W-1:0]    start_offset,
  output logic      [nlrs_pkg::OFS_W-1:0]    end_offset,
  output logic      [nlrs_pkg::OFS_W-1:0]    first_line,
  output logic                               last_seg
);

  logic [nlrs_pkg::OFS_W-1:0] total_len;
  logic [nlrs_pkg::CNT_W-1:0] seg_count;

  logic [nlrs_pkg::OFS_W-1:0] byte_pos;
  logic [nlrs_pkg::OFS_W-1:0] lines_since_cut;
  logic [nlrs_pkg::CNT_W-1:0] next_cut;
  logic [nlrs_pkg::OFS_W-1:0] nominal_cut;
  logic [nlrs_pkg::OFS_W-1:0] range_start;
  logic [nlrs_pkg::OFS_W-1:0] range_line_base;
  logic                       finished;
  logic                       is_nl;

  logic [nlrs_pkg::OFS_W-1:0] size_eff;
  logic [nlrs_pkg::CNT_W-1:0] count_eff;
  logic [nlrs_pkg::OFS_W-1:0] quotient;
  logic                       div_done;
  logic                       more;
  logic                       placing;
  logic [nlrs_pkg::OFS_W-1:0] cut_pos;

  always_comb begin
    size_eff = (total_len == '0) ? nlrs_pkg::OFS_W'(1) : total_len;
    if (seg_count == '0) begin
      count_eff = nlrs_pkg::CNT_W'(1);
    end else if (seg_count > nlrs_pkg::CNT_W'(nlrs_pkg::MAX_SEG)) begin
      count_eff = nlrs_pkg::CNT_W'(nlrs_pkg::MAX_SEG);
    end else begin
      count_eff = seg_count;
    end
  end

  nlrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (size_eff),
    .divisor  (count_eff),
    .quotient (quotient),
    .done     (div_done)
  );

  assign more    = next_cut < count_eff;
  assign placing = cmd.cut_nl | cmd.cut_end;
  assign cut_pos = cmd.cut_nl ? byte_pos : size_eff;

  always_comb begin
    status.first       = byte_pos == '0;
    status.div_done    = div_done;
    status.cut_nl_ok   = is_nl && more && (byte_pos >= nominal_cut);
    status.end_reached = byte_pos >= size_eff;
    status.more        = more;
    status.finished    = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_len <= nlrs_pkg::OFS_W'(1);
      seg_count <= nlrs_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nlrs_pkg::REG_TOTAL_LEN: total_len <= cfg_data;
        nlrs_pkg::REG_SEG_COUNT: seg_count <= cfg_data[nlrs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos        <= '0;
      lines_since_cut <= '0;
      next_cut        <= nlrs_pkg::CNT_W'(1);
      nominal_cut     <= nlrs_pkg::OFS_W'(1);
      range_start     <= '0;
      range_line_base <= '0;
      finished        <= 1'b0;
      is_nl           <= 1'b0;
    end else begin
      if (cmd.take) begin
        byte_pos <= byte_pos + 1'b1;
        is_nl    <= data_byte == nlrs_pkg::NEWLINE;
        if (data_byte == nlrs_pkg::NEWLINE) begin
          lines_since_cut <= lines_since_cut + 1'b1;
        end
      end
      if (cmd.load_chunk) begin
        nominal_cut <= quotient;
        next_cut    <= nlrs_pkg::CNT_W'(1);
      end
      if (placing) begin
        range_start     <= cut_pos;
        range_line_base <= range_line_base + lines_since_cut;
        lines_since_cut <= '0;
        next_cut        <= next_cut + 1'b1;
        nominal_cut     <= nominal_cut + quotient;
      end
      if (cmd.final_out) begin
        finished <= 1'b1;
      end
    end
  end

  // result register, held until taken
  always_ff @(posedge clk) begin
    if (placing || cmd.final_out) begin
      seg_index    <= placing ? nlrs_pkg::IDX_W'(next_cut - 1'b1)
                              : nlrs_pkg::IDX_W'(count_eff - 1'b1);
      start_offset <= range_start;
      end_offset   <= cut_pos;
      first_line   <= range_line_base;
      last_seg     <= cmd.final_out;
    end
  end

endmodule
`default_nettype wire

// ----- design/nlrs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nlrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire nlrs_pkg::status_t  status,
  output nlrs_pkg::cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        // bytes past the end of the stream are taken and dropped
        if (in_valid && !status.finished) begin
          cmd.take      = 1'b1;
          cmd.div_start = status.first;
          state_next    = status.first ? S_DIV : S_CHECK;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.load_chunk = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.cut_nl_ok) begin
          cmd.cut_nl = 1'b1;
          state_next = S_EMIT;
        end else if (status.end_reached) begin
          if (status.more) begin
            cmd.cut_end = 1'b1;
          end else begin
            cmd.final_out = 1'b1;
          end
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          state_next = status.finished ? S_IDLE : S_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_EMIT;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int SETTLE      = 60;      // covers the first-byte division
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam logic [nlrs_pkg::OFS_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [nlrs_pkg::IDX_W-1:0] idx;
    logic [nlrs_pkg::OFS_W-1:0] lo;
    logic [nlrs_pkg::OFS_W-1:0] hi;
    logic [nlrs_pkg::OFS_W-1:0] line;
    logic                       last;
  } range_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       reg_idx;  // don't-care on byte rows
    logic [nlrs_pkg::OFS_W-1:0] val;
    logic                       typed;
    range_t                     want;
  } dir_row_t;

  localparam range_t NONE = '0;
  localparam int DIR_N = 24;

  // chunk latched on the first byte: 192 / 64 = 3
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_CFG,  nlrs_pkg::REG_SEG_COUNT, 40'd127,              1'b0, NONE},  // saturates to 64
    '{ROW_CFG,  nlrs_pkg::REG_TOTAL_LEN, 40'd192,              1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h00,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'hFF,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b1,
      '{6'd0, 40'd0, 40'd3, 40'd0, 1'b0}},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h55,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'hAA,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'hF5,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h0B,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h09,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h80,               1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'h7F,               1'b0, NONE},
    // three cuts on one newline
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    // mid-stream: no interior cuts
    '{ROW_CFG,  nlrs_pkg::REG_SEG_COUNT, 40'd1,                1'b0, NONE},
    '{ROW_CFG,  nlrs_pkg::REG_TOTAL_LEN, SIZE_MAX,             1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    // zero count acts as one
    '{ROW_CFG,  nlrs_pkg::REG_SEG_COUNT, 40'd0,                1'b0, NONE},
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE},
    '{ROW_CFG,  nlrs_pkg::REG_SEG_COUNT, 40'd64,               1'b0, NONE},
    // catch-up cuts
    '{ROW_BYTE, nlrs_pkg::REG_TOTAL_LEN, 40'(nlrs_pkg::NEWLINE), 1'b0, NONE}
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [nlrs_pkg::OFS_W-1:0]    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [nlrs_pkg::BYTE_W-1:0]   data_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [nlrs_pkg::IDX_W-1:0]    seg_index;
  logic [nlrs_pkg::OFS_W-1:0]    start_offset;
  logic [nlrs_pkg::OFS_W-1:0]    end_offset;
  logic [nlrs_pkg::OFS_W-1:0]    first_line;
  logic                          last_seg;

  // splitter state as seen from outside
  logic [nlrs_pkg::OFS_W-1:0] size_reg   = 40'd1;
  logic [nlrs_pkg::CNT_W-1:0] count_reg  = 7'd1;
  logic [nlrs_pkg::OFS_W-1:0] stream_pos = '0;
  logic [nlrs_pkg::OFS_W-1:0] nl_pending = '0;
  logic [nlrs_pkg::OFS_W-1:0] cut_mark   = 40'd1;
  logic [nlrs_pkg::OFS_W-1:0] chunk      = 40'd1;
  logic [nlrs_pkg::OFS_W-1:0] seg_lo     = '0;
  logic [nlrs_pkg::OFS_W-1:0] seg_line   = '0;
  int                         cut_no     = 1;
  bit                         stream_done = 1'b0;

  range_t ranges_due [$];
  int     bad_ranges = 0;
  int     cycle_cnt  = 0;
  int     stall_mode = 0;
  int     stall_left = 0;

  newline_aligned_range_splitter_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .seg_index    (seg_index),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .first_line   (first_line),
    .last_seg     (last_seg)
  );

  always #4 clk = ~clk;

  task automatic close_range(input logic [nlrs_pkg::OFS_W-1:0] hi);
    range_t r;
    r = '{nlrs_pkg::IDX_W'(cut_no - 1), seg_lo, hi, seg_line, 1'b0};
    ranges_due.push_back(r);
    seg_lo     = hi;
    seg_line   = seg_line + nl_pending;
    nl_pending = '0;
    cut_no++;
    cut_mark   = cut_mark + chunk;
  endtask

  task automatic split_byte(input logic [nlrs_pkg::BYTE_W-1:0] b);
    logic [nlrs_pkg::OFS_W-1:0] size;
    int                         n;
    range_t                     r;
    if (stream_done) return;
    size = (size_reg == '0) ? nlrs_pkg::OFS_W'(1) : size_reg;
    n = (count_reg == '0) ? 1 :
        (int'(count_reg) > nlrs_pkg::MAX_SEG) ? nlrs_pkg::MAX_SEG : int'(count_reg);
    if (stream_pos == '0) begin
      chunk    = size / nlrs_pkg::OFS_W'(n);
      cut_mark = chunk;
      cut_no   = 1;
    end
    stream_pos = stream_pos + 1'b1;
    if (b == nlrs_pkg::NEWLINE) begin
      nl_pending = nl_pending + 1'b1;
      while (cut_no + 1 <= n && stream_pos >= cut_mark) close_range(stream_pos);
    end
    if (stream_pos >= size) begin
      while (cut_no + 1 <= n) close_range(size);
      r = '{nlrs_pkg::IDX_W'(n - 1), seg_lo, size, seg_line, 1'b1};
      ranges_due.push_back(r);
      stream_done = 1'b1;
    end
  endtask

  task automatic send_byte(input logic [nlrs_pkg::BYTE_W-1:0] b);
    int gap;
    int r;
    bit taken;
    r   = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic feed(input logic [nlrs_pkg::BYTE_W-1:0] b);
    send_byte(b);
    split_byte(b);
  endtask

  task automatic write_reg(input logic idx, input logic [nlrs_pkg::OFS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nlrs_pkg::REG_TOTAL_LEN) size_reg = val;
    else count_reg = val[nlrs_pkg::CNT_W-1:0];
    @(posedge clk);
  endtask

  // drain every pending range, then let any byte still in flight settle
  task automatic go_quiet();
    in_valid <= 1'b0;
    while (ranges_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 9);
      stall_left = (stall_mode >= 8) ? $urandom_range(5, 30) : $urandom_range(4, 40);
    end
    stall_left--;
    if (stall_mode < 5) out_stall <= 1'b0;
    else if (stall_mode < 8) out_stall <= ($urandom_range(0, 2) == 0);
    else out_stall <= 1'b1;
  end

  // inputs only move at the rising edge, so the negedge view holds for the next edge
  always @(negedge clk) begin
    range_t got;
    range_t want;
    if (out_valid === 1'b1 && out_stall == 1'b0) begin
      got = '{seg_index, start_offset, end_offset, first_line, last_seg};
      if (ranges_due.size() == 0) begin
        bad_ranges++;
        if (bad_ranges <= 10)
          $display("unexpected range: idx %0d lo %0d hi %0d line %0d last %0b",
                   got.idx, got.lo, got.hi, got.line, got.last);
      end else begin
        want = ranges_due.pop_front();
        if (got !== want) begin
          bad_ranges++;
          if (bad_ranges <= 10) begin
            $display("range mismatch: exp idx %0d lo %0d hi %0d line %0d last %0b",
                     want.idx, want.lo, want.hi, want.line, want.last);
            $display("                got idx %0d lo %0d hi %0d line %0d last %0b",
                     got.idx, got.lo, got.hi, got.line, got.last);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t                   row;
    logic [nlrs_pkg::OFS_W-1:0] val;
    int                         depth;
    int                         nl_pct;
    int                         pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        go_quiet();
        write_reg(row.reg_idx, row.val);
      end else if (row.typed) begin
        send_byte(row.val[nlrs_pkg::BYTE_W-1:0]);
        depth = ranges_due.size();
        split_byte(row.val[nlrs_pkg::BYTE_W-1:0]);
        while (ranges_due.size() > depth) void'(ranges_due.pop_back());
        ranges_due.push_back(row.want);
      end else begin
        feed(row.val[nlrs_pkg::BYTE_W-1:0]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      go_quiet();
      pick = $urandom_range(0, 9);
      val  = nlrs_pkg::OFS_W'({$urandom, $urandom});
      if (pick == 0) val[nlrs_pkg::CNT_W-1:0] = '0;
      else if (pick == 1) val[nlrs_pkg::CNT_W-1:0] = 7'd1;
      else if (pick == 2) val[nlrs_pkg::CNT_W-1:0] = nlrs_pkg::CNT_W'($urandom_range(2, 20));
      else if (pick == 3)
        val[nlrs_pkg::CNT_W-1:0] =
          nlrs_pkg::CNT_W'($urandom_range(nlrs_pkg::MAX_SEG + 1, 127));
      else val[nlrs_pkg::CNT_W-1:0] = nlrs_pkg::CNT_W'(nlrs_pkg::MAX_SEG);
      if ($urandom_range(0, 1)) val[nlrs_pkg::OFS_W-1:nlrs_pkg::CNT_W] = '0;
      write_reg(nlrs_pkg::REG_SEG_COUNT, val);
      if ($urandom_range(0, 1)) begin
        val     = nlrs_pkg::OFS_W'({$urandom, $urandom});
        val[12] = 1'b1;  // end stays well past the bytes still to come
        if ($urandom_range(0, 3) == 0) val = SIZE_MAX;
        write_reg(nlrs_pkg::REG_TOTAL_LEN, val);
      end
      nl_pct = $urandom_range(10, 70);
      repeat ($urandom_range(20, 32))
        feed(($urandom_range(0, 99) < nl_pct) ? nlrs_pkg::NEWLINE
                                              : nlrs_pkg::BYTE_W'($urandom));
    end

    // shrink the size under the current position: the next item closes every range
    go_quiet();
    write_reg(nlrs_pkg::REG_SEG_COUNT, nlrs_pkg::OFS_W'(127));
    write_reg(nlrs_pkg::REG_TOTAL_LEN, nlrs_pkg::OFS_W'($urandom_range(0, 1)));
    feed(nlrs_pkg::NEWLINE);
    repeat (6) feed(nlrs_pkg::BYTE_W'($urandom));  // past the end, ignored

    go_quiet();
    if (bad_ranges == 0 && ranges_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- newline_aligned_range_splitter_core.f -----
design/nlrs_pkg.sv
design/nlrs_div.sv
design/nlrs_datapath.sv
design/nlrs_ctrl.sv
design/newline_aligned_range_splitter_core.sv
tb/tb_top.sv
